/* hw/rtl/bemau_pkg.sv */
// shared types and constants of the big-endian memory access unit
package bemau_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int BANKS     = 4;
    localparam int ROWS      = MEM_BYTES / BANKS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ADDR_MASK    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STRICT_ALIGN = CFG_IDX_W'(1);

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    // reserved size code, always an address error
    localparam logic [1:0] SIZE_RSVD = 2'd3;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic        action;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        status;
    } t_out_item;

    // per-bank access decoded from one item
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [7:0]       wbyte;
    } t_bank_cmd;

    // what the read stage needs, registered beside the ram read data
    typedef struct packed {
        logic       bad;
        logic       action;
        logic [1:0] access_size;
        logic [1:0] first_lane;
    } t_meta;

endpackage

/* hw/rtl/bemau_ram.sv */
// generic single-port synchronous ram with registered read data
module bemau_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bemau_lane.sv */
// address check and split of one access onto the four byte banks
module bemau_lane (
    input  bemau_pkg::t_in_item  i_item,
    input  logic [31:0]          i_addr_mask,
    input  logic                 i_strict_align,
    output bemau_pkg::t_bank_cmd o_cmd [bemau_pkg::BANKS],
    output bemau_pkg::t_meta     o_meta
);
    import bemau_pkg::*;

    logic [31:0] span;
    logic [31:0] last;
    logic [31:0] first;
    logic [31:0] lane_addr [BANKS];
    logic [1:0]  k [BANKS];
    logic        bad;
    logic        multi;

    always_comb begin
        multi = 1'b0;
        span  = 32'd0;
        case (i_item.access_size)
            SIZE_BYTE: span = 32'd0;
            SIZE_WORD: begin
                span  = 32'd1;
                multi = 1'b1;
            end
            SIZE_LONG: begin
                span  = 32'd3;
                multi = 1'b1;
            end
            default:   span = 32'd0;
        endcase

        last  = (i_item.address + span) & i_addr_mask;
        first = last - span;

        bad = (i_item.access_size == SIZE_RSVD)
            || (last >= 32'(MEM_BYTES))
            || (last < span)
            || (i_strict_align && multi && i_item.address[0]);

        for (int b = 0; b < BANKS; b++) begin
            k[b]         = 2'(b) - first[1:0];
            lane_addr[b] = first + {30'd0, k[b]};
            o_cmd[b].row = lane_addr[b][ROW_W+1:2];
            o_cmd[b].en  = (32'(k[b]) <= span);
            case (i_item.access_size)
                SIZE_WORD: o_cmd[b].wbyte = k[b][0] ? i_item.write_data[7:0]
                                                    : i_item.write_data[15:8];
                SIZE_LONG: begin
                    case (k[b])
                        2'd0:    o_cmd[b].wbyte = i_item.write_data[31:24];
                        2'd1:    o_cmd[b].wbyte = i_item.write_data[23:16];
                        2'd2:    o_cmd[b].wbyte = i_item.write_data[15:8];
                        default: o_cmd[b].wbyte = i_item.write_data[7:0];
                    endcase
                end
                default:   o_cmd[b].wbyte = i_item.write_data[7:0];
            endcase
        end

        o_meta.bad         = bad;
        o_meta.action      = i_item.action;
        o_meta.access_size = i_item.access_size;
        o_meta.first_lane  = first[1:0];
    end

endmodule

/* hw/rtl/big_endian_memory_access_unit_top.sv */
// top level of the big-endian byte-addressed memory access unit
// each item passes the ram read stage and then the output register before its result is presented
// throughput: one item per cycle; the four byte banks serve a long access together in a single ram access
// input stalls only while both stages hold items and the receiver is not ready
// reset clears the pipeline valids and sets addr_mask to all ones and strict_align to 1
// memory contents are not cleared by reset and read back undefined until written
module big_endian_memory_access_unit_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  bemau_pkg::t_in_item                   i_in_item,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output bemau_pkg::t_out_item                  o_out_item,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bemau_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);
    import bemau_pkg::*;

    // configuration registers
    logic [31:0] r_addr_mask;
    logic        r_strict_align;

    // ram read stage and output register
    logic        r_s1_valid;
    t_meta       r_s1_meta;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    t_bank_cmd   cmd [BANKS];
    t_meta       meta;
    logic [7:0]  rd [BANKS];
    logic        accept;
    logic        out_free;
    logic        s1_move;
    logic        do_write;

    // the user must write config only while idle (the block does not enforce it), so no hazard against items in flight
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_mask    <= 32'hFFFF_FFFF;
            r_strict_align <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ADDR_MASK:    r_addr_mask    <= i_cfg_data;
                REG_STRICT_ALIGN: r_strict_align <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: the read stage may refill whenever it empties into the output register
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign accept     = i_in_valid && o_in_ready;

    // bounds and alignment check, bank steering
    bemau_lane u_lane (
        .i_item         (i_in_item),
        .i_addr_mask    (r_addr_mask),
        .i_strict_align (r_strict_align),
        .o_cmd          (cmd),
        .o_meta         (meta)
    );

    // a failed access writes nothing
    assign do_write = accept && !meta.bad && (meta.action == ACT_WRITE);

    // one byte bank per low address pair; bank b holds addresses with addr[1:0] == b
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        bemau_ram #(
            .DEPTH (ROWS),
            .WIDTH (8),
            .AW    (ROW_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (accept),
            .i_we    (do_write && cmd[b].en),
            .i_addr  (cmd[b].row),
            .i_wdata (cmd[b].wbyte),
            .o_rdata (rd[b])
        );
    end

    // big-endian assembly: first byte lands in the most significant position
    always_comb begin
        n_out_item.read_data = 32'd0;
        n_out_item.status    = r_s1_meta.bad ? STATUS_ERR : STATUS_OK;
        if (!r_s1_meta.bad && (r_s1_meta.action == ACT_READ)) begin
            case (r_s1_meta.access_size)
                SIZE_BYTE: n_out_item.read_data = {24'd0, rd[r_s1_meta.first_lane]};
                SIZE_WORD: n_out_item.read_data = {16'd0,
                    rd[r_s1_meta.first_lane],
                    rd[r_s1_meta.first_lane + 2'd1]};
                SIZE_LONG: n_out_item.read_data = {
                    rd[r_s1_meta.first_lane],
                    rd[r_s1_meta.first_lane + 2'd1],
                    rd[r_s1_meta.first_lane + 2'd2],
                    rd[r_s1_meta.first_lane + 2'd3]};
                default:   n_out_item.read_data = 32'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: ram data holds while the read stage stalls (no new read issued)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
        if (s1_move) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* dv/big_endian_memory_access_unit_top_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench of the big-endian memory access unit top level
module big_endian_memory_access_unit_top_tb;
    import bemau_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_item             in_item = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_ready;
    logic                 out_valid;
    t_out_item            out_item;
    logic                 cfg_ready;

    big_endian_memory_access_unit_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // accesses waiting to be driven, and the results they must produce
    t_in_item  accesses_pending[$];
    t_out_item results_due[$];

    // stimulus-side view: which bytes hold data, and the settings in force
    bit          byte_written[MEM_BYTES];
    logic [31:0] plan_mask = 32'hFFFF_FFFF;
    bit          plan_align = 1'b1;

    // predictor state: its own memory image and register copies
    logic [7:0]  mem_image[MEM_BYTES];
    logic [31:0] model_mask = 32'hFFFF_FFFF;
    bit          model_align = 1'b1;

    int items_queued = 0;
    int results_done = 0;
    int mismatch_count = 0;

    // idling controls, per side, in percent per cycle
    int  in_idle_pct = 20;
    int  out_idle_pct = 20;
    int  in_gap = 0;
    int  out_hold = 0;
    bit  long_hold_req = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    // decides fault and the span of bytes touched; shared by stimulus and predictor
    function automatic bit access_fault(input logic [1:0] sz, input logic [31:0] addr,
                                        input logic [31:0] mask, input bit align,
                                        output int unsigned first, output int unsigned nb);
        logic [31:0] last;
        nb = (sz == SIZE_RSVD) ? 1 : (1 << sz);
        // last byte wraps at 32 bits, then the mask applies
        last = (addr + 32'(nb - 1)) & mask;
        first = last - (nb - 1);
        return (sz == SIZE_RSVD) || (last >= 32'(MEM_BYTES)) || (last < 32'(nb - 1))
            || (align && nb > 1 && addr[0]);
    endfunction

    // expected result of one access; applies writes to the memory image
    function automatic t_out_item predict_access(input t_in_item it);
        t_out_item   res;
        int unsigned first;
        int unsigned nb;
        bit          bad;
        res.read_data = '0;
        bad = access_fault(it.access_size, it.address, model_mask, model_align, first, nb);
        res.status = bad ? STATUS_ERR : STATUS_OK;
        if (!bad) begin
            for (int i = 0; i < nb; i++) begin
                // lowest address carries the most significant byte
                if (it.action == ACT_READ) begin
                    res.read_data = {res.read_data[23:0], mem_image[first + i]};
                end else begin
                    mem_image[first + i] = 8'(it.write_data >> (8 * (nb - 1 - i)));
                end
            end
        end
        return res;
    endfunction

    // queue one access and track which bytes it fills
    task automatic queue_access(input logic act, input logic [1:0] sz,
                                input logic [31:0] addr, input logic [31:0] data);
        t_in_item    it;
        int unsigned first;
        int unsigned nb;
        it = '{action: act, access_size: sz, address: addr, write_data: data};
        if (!access_fault(sz, addr, plan_mask, plan_align, first, nb) && act == ACT_WRITE) begin
            for (int i = 0; i < nb; i++) byte_written[first + i] = 1'b1;
        end
        accesses_pending.push_back(it);
        items_queued++;
    endtask

    // random accesses, mostly in two small windows so reads find written data
    task automatic queue_random(input int n);
        logic        act;
        logic [1:0]  sz;
        logic [31:0] addr;
        int          pick;
        int unsigned first;
        int unsigned nb;
        for (int k = 0; k < n; k++) begin
            act = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE;
            pick = $urandom_range(0, 19);
            if (pick == 0) sz = SIZE_RSVD;
            else if (pick < 8) sz = SIZE_BYTE;
            else if (pick < 14) sz = SIZE_WORD;
            else sz = SIZE_LONG;
            pick = $urandom_range(0, 99);
            if (pick < 45) addr = $urandom_range(0, 127);
            else if (pick < 70) addr = MEM_BYTES - 64 + $urandom_range(0, 67);
            else if (pick < 85) addr = $urandom_range(0, MEM_BYTES - 1);
            else addr = $urandom;
            // keep most multi-byte accesses aligned when alignment is enforced
            if (sz != SIZE_BYTE && plan_align && $urandom_range(0, 9) != 0) addr[0] = 1'b0;
            // a good read of a never-written byte turns into a write
            if (!access_fault(sz, addr, plan_mask, plan_align, first, nb) && act == ACT_READ) begin
                for (int i = 0; i < nb; i++) begin
                    if (!byte_written[first + i]) act = ACT_WRITE;
                end
            end
            queue_access(act, sz, addr, $urandom);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every result is in and the two-stage pipeline has emptied
    task automatic wait_drained();
        while (results_done < items_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] mask, input bit align,
                                  input int in_pct, input int out_pct);
        wait_drained();
        write_cfg(REG_ADDR_MASK, mask);
        write_cfg(REG_STRICT_ALIGN, {31'd0, align});
        plan_mask = mask;
        plan_align = align;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
    endtask

    // sender: one nonblocking update of valid per edge, bursts of idle cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (accesses_pending.size() == 0) begin
                in_valid <= 1'b0;
            end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
                in_gap = $urandom_range(1, 10) - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_item <= accesses_pending.pop_front();
            end
        end
    end

    // receiver: short random stalls, and one long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            out_hold = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            out_ready <= 1'b0;
        end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
            out_hold = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (mismatch_count < 10) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
        end
        mismatch_count++;
    endtask

    // monitor: register writes, accepted items into the predictor, results checked in order
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            model_mask = 32'hFFFF_FFFF;
            model_align = 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ADDR_MASK) model_mask = cfg_data;
                else if (cfg_index == REG_STRICT_ALIGN) model_align = cfg_data[0];
            end
            if (in_valid && in_ready) results_due.push_back(predict_access(in_item));
            if (out_valid && out_ready) begin
                results_done++;
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", '0, out_item.read_data);
                end else begin
                    want = results_due.pop_front();
                    if (out_item.read_data !== want.read_data)
                        flag_mismatch("read_data", want.read_data, out_item.read_data);
                    if (out_item.status !== want.status)
                        flag_mismatch("status", {31'd0, want.status}, {31'd0, out_item.status});
                end
            end
        end
    end

    // stimulus sequence and verdict
    initial begin
        logic [31:0] rnd;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed accesses under reset settings: all-ones mask, strict alignment
        queue_access(ACT_WRITE, SIZE_LONG, 32'd0, 32'h1122_3344);
        queue_access(ACT_READ,  SIZE_LONG, 32'd0, 32'd0);
        queue_access(ACT_READ,  SIZE_BYTE, 32'd0, 32'd0);
        queue_access(ACT_READ,  SIZE_BYTE, 32'd3, 32'hFFFF_FFFF);
        queue_access(ACT_READ,  SIZE_WORD, 32'd2, 32'd0);
        // top byte of memory, data with all bits set
        queue_access(ACT_WRITE, SIZE_BYTE, MEM_BYTES - 1, 32'hFFFF_FFFF);
        queue_access(ACT_READ,  SIZE_BYTE, MEM_BYTES - 1, 32'd0);
        queue_access(ACT_WRITE, SIZE_LONG, MEM_BYTES - 4, 32'd0);
        queue_access(ACT_WRITE, SIZE_WORD, MEM_BYTES - 2, 32'h1234_BEEF);
        queue_access(ACT_READ,  SIZE_LONG, MEM_BYTES - 4, 32'd0);
        // long running past the end of memory
        queue_access(ACT_WRITE, SIZE_LONG, MEM_BYTES - 2, 32'hDEAD_BEEF);
        queue_access(ACT_READ,  SIZE_LONG, MEM_BYTES - 2, 32'd0);
        // first byte exactly at the memory size
        queue_access(ACT_READ,  SIZE_BYTE, MEM_BYTES, 32'd0);
        queue_access(ACT_WRITE, SIZE_BYTE, MEM_BYTES, 32'h0000_00AA);
        // odd word and long addresses
        queue_access(ACT_READ,  SIZE_WORD, 32'd1, 32'd0);
        queue_access(ACT_WRITE, SIZE_LONG, 32'd3, 32'h5555_5555);
        // reserved size code
        queue_access(ACT_READ,  SIZE_RSVD, 32'd0, 32'd0);
        queue_access(ACT_WRITE, SIZE_RSVD, 32'd0, 32'hFFFF_FFFF);
        // top of the 32-bit range: the long and word spans would start below address zero
        queue_access(ACT_WRITE, SIZE_LONG, 32'hFFFF_FFFE, 32'hA5A5_A5A5);
        queue_access(ACT_READ,  SIZE_WORD, 32'hFFFF_FFFF, 32'd0);
        queue_access(ACT_READ,  SIZE_BYTE, 32'hFFFF_FFFF, 32'd0);
        // failed writes above must have left this untouched
        queue_access(ACT_READ,  SIZE_LONG, 32'd0, 32'd0);
        queue_random(350);

        // 64 KiB wrap, unaligned allowed; the receiver holds off so the input backs up
        apply_settings(32'h0000_FFFF, 1'b0, 15, 15);
        queue_access(ACT_READ,  SIZE_WORD, 32'd1, 32'd0);
        queue_access(ACT_READ,  SIZE_LONG, 32'h0000_FFFE, 32'd0);
        queue_access(ACT_WRITE, SIZE_WORD, 32'hFFFF_FFFF, 32'h0000_1234);
        queue_access(ACT_READ,  SIZE_LONG, 32'h0001_0000, 32'd0);
        queue_random(500);
        long_hold_req = 1'b1;

        // zero mask folds every byte access onto address zero and faults wider ones; no idling in this stretch
        apply_settings(32'h0000_0000, 1'b1, 0, 0);
        queue_random(100);

        apply_settings(32'hFFFF_FFFF, 1'b0, 25, 5);
        queue_random(350);

        // random mask, half the time narrowed to its low 18 bits
        rnd = $urandom;
        apply_settings(rnd[0] ? {14'd0, rnd[17:0]} : rnd, 1'($urandom_range(0, 1)), 5, 25);
        queue_random(250);

        // closing stretch without idling
        apply_settings(32'h0001_FFFF, 1'b1, 0, 0);
        queue_random(350);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("big_endian_memory_access_unit_top verification clean");
        end else begin
            $display("big_endian_memory_access_unit_top verification failed");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #2000000;
        $display("big_endian_memory_access_unit_top verification failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bemau_pkg.sv
hw/rtl/bemau_ram.sv
hw/rtl/bemau_lane.sv
hw/rtl/big_endian_memory_access_unit_top.sv
dv/big_endian_memory_access_unit_top_tb.sv
